[sv/assert_macros.svh]
// Assertion macros for the fan decomposition RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property on clk, disabled while rst_n is low.
`define TFD_ASSERT(lbl, prop, msg) lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never hold at a clock edge.
`define TFD_NEVER(lbl, cond, msg) lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TFD_ASSERT(lbl, prop, msg)
`define TFD_NEVER(lbl, cond, msg)
`endif
`endif

[sv/tfd_pkg.sv]
// Types, constants and tables of the triangle fan decomposition block.
`default_nettype none
package tfd_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int ANGLE_WIDTH  = 16;
    localparam int RADIUS_WIDTH = COORD_WIDTH + 1;
    localparam int DELTA_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH   = 2 * DELTA_WIDTH;
    localparam int SUM_WIDTH    = PROD_WIDTH;
    localparam int CX_WIDTH     = COORD_WIDTH + 4;
    localparam int TURN_WIDTH   = 32;
    localparam int CORDIC_STEPS = 32;
    localparam int SQRT_STEPS   = SUM_WIDTH / 2;
    localparam int ROOT_WIDTH   = SQRT_STEPS;
    localparam int REM_WIDTH    = SQRT_STEPS + 3;
    localparam int PIPE_STAGES  = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [TURN_WIDTH-1:0] TURN_HALF  = 32'h8000_0000;
    localparam logic [TURN_WIDTH-1:0] ROUND_HALF = 32'd1 << (31 - ANGLE_WIDTH);

    localparam logic [1:0] ST_EDGE    = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_INSIDE  = 2'd2;
    localparam logic [1:0] ST_DEGEN   = 2'd3;

    localparam logic [1:0] SLOT_0 = 2'd0;
    localparam logic [1:0] SLOT_1 = 2'd1;
    localparam logic [1:0] SLOT_2 = 2'd2;

    localparam logic [TURN_WIDTH-1:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] first_x;
        logic signed [COORD_WIDTH-1:0] first_y;
        logic signed [COORD_WIDTH-1:0] second_x;
        logic signed [COORD_WIDTH-1:0] second_y;
        logic signed [COORD_WIDTH-1:0] third_x;
        logic signed [COORD_WIDTH-1:0] third_y;
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
    } item_t;

    typedef struct packed {
        logic [1:0]                    status;
        logic signed [ANGLE_WIDTH-1:0] start_angle;
        logic [ANGLE_WIDTH-1:0]        apex_angle;
        logic [RADIUS_WIDTH-1:0]       first_radius;
        logic [RADIUS_WIDTH-1:0]       second_radius;
        logic                          negative;
        logic                          last;
    } result_t;

    // Per-item classification carried from front to emitter.
    typedef struct packed {
        logic [1:0] status;
        logic       degen;
        logic       neg1;
        logic       zero1;
        logic       neg2;
        logic       zero2;
    } info_t;

    // Queue entry: rotated vertex deltas plus classification.
    typedef struct packed {
        logic [2:0][DELTA_WIDTH-1:0] dx;
        logic [2:0][DELTA_WIDTH-1:0] dy;
        info_t                       info;
    } desc_t;

    typedef struct packed {
        logic [1:0] slot;
        info_t      info;
    } tag_t;

    typedef struct packed {
        logic [TURN_WIDTH-1:0]   turn;
        logic [RADIUS_WIDTH-1:0] rad;
        logic                    atp;
    } ray_res_t;

endpackage
`default_nettype wire

[sv/tfd_front.sv]
// Front end: vertex deltas, exact edge orientations, status and rotation.
`default_nettype none
module tfd_front (
    input  logic            clk,
    input  logic            rst_n,
    input  tfd_pkg::item_t  item,
    input  logic            item_valid,
    output logic            item_stall,
    output tfd_pkg::desc_t  desc,
    output logic            desc_valid,
    input  logic            desc_full
);
    import tfd_pkg::*;

    localparam logic [1:0] ROT_0 = 2'd0;
    localparam logic [1:0] ROT_1 = 2'd1;
    localparam logic [1:0] ROT_2 = 2'd2;

    logic signed [DELTA_WIDTH-1:0] dx0, dx1, dx2, dy0, dy1, dy2;
    logic signed [PROD_WIDTH-1:0]  pab0, pab1, pab2, pcd0, pcd1, pcd2;

    logic                              v1_reg, v2_reg;
    logic [2:0][DELTA_WIDTH-1:0]       dx_reg, dy_reg;
    logic signed [PROD_WIDTH-1:0]      pab_reg [3];
    logic signed [PROD_WIDTH-1:0]      pcd_reg [3];
    desc_t                             desc_reg, desc_next;

    logic signed [PROD_WIDTH:0] diff [3];
    logic [2:0] pos, neg, zero;
    logic [1:0] rot;
    logic       f1_free, f2_free;

    assign f2_free    = !v2_reg || !desc_full;
    assign f1_free    = !v1_reg || f2_free;
    assign item_stall = !f1_free;
    assign desc       = desc_reg;
    assign desc_valid = v2_reg;

    always_comb
    begin
        dx0  = DELTA_WIDTH'(item.first_x)  - DELTA_WIDTH'(item.point_x);
        dy0  = DELTA_WIDTH'(item.first_y)  - DELTA_WIDTH'(item.point_y);
        dx1  = DELTA_WIDTH'(item.second_x) - DELTA_WIDTH'(item.point_x);
        dy1  = DELTA_WIDTH'(item.second_y) - DELTA_WIDTH'(item.point_y);
        dx2  = DELTA_WIDTH'(item.third_x)  - DELTA_WIDTH'(item.point_x);
        dy2  = DELTA_WIDTH'(item.third_y)  - DELTA_WIDTH'(item.point_y);
        pab0 = dx0 * dy1;
        pcd0 = dy0 * dx1;
        pab1 = dx1 * dy2;
        pcd1 = dy1 * dx2;
        pab2 = dx2 * dy0;
        pcd2 = dy2 * dx0;
    end

    always_ff @(posedge clk)
    begin
        if (f1_free)
        begin
            dx_reg     <= {dx2, dx1, dx0};
            dy_reg     <= {dy2, dy1, dy0};
            pab_reg[0] <= pab0;
            pab_reg[1] <= pab1;
            pab_reg[2] <= pab2;
            pcd_reg[0] <= pcd0;
            pcd_reg[1] <= pcd1;
            pcd_reg[2] <= pcd2;
        end
        if (f2_free)
        begin
            desc_reg <= desc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (f1_free)
            begin
                v1_reg <= item_valid;
            end
            if (f2_free)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    // Classify the registered products and rotate to the first positive edge.
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            diff[j] = (PROD_WIDTH+1)'(pab_reg[j]) - (PROD_WIDTH+1)'(pcd_reg[j]);
            zero[j] = (diff[j] == '0);
            neg[j]  = diff[j][PROD_WIDTH];
            pos[j]  = !zero[j] && !neg[j];
        end

        priority if (pos[0]) rot = ROT_0;
        else if (pos[1])     rot = ROT_1;
        else if (pos[2])     rot = ROT_2;
        else                 rot = ROT_0;

        desc_next.info.degen = (pos == 3'b000);
        priority if (desc_next.info.degen) desc_next.info.status = ST_DEGEN;
        else if (zero != 3'b000)           desc_next.info.status = ST_EDGE;
        else if (neg != 3'b000)            desc_next.info.status = ST_OUTSIDE;
        else                               desc_next.info.status = ST_INSIDE;

        unique case (rot)
            ROT_1:
            begin
                desc_next.dx = {dx_reg[0], dx_reg[2], dx_reg[1]};
                desc_next.dy = {dy_reg[0], dy_reg[2], dy_reg[1]};
                desc_next.info.neg1  = neg[2];
                desc_next.info.zero1 = zero[2];
                desc_next.info.neg2  = neg[0];
                desc_next.info.zero2 = zero[0];
            end
            ROT_2:
            begin
                desc_next.dx = {dx_reg[1], dx_reg[0], dx_reg[2]};
                desc_next.dy = {dy_reg[1], dy_reg[0], dy_reg[2]};
                desc_next.info.neg1  = neg[0];
                desc_next.info.zero1 = zero[0];
                desc_next.info.neg2  = neg[1];
                desc_next.info.zero2 = zero[1];
            end
            default:
            begin
                desc_next.dx = dx_reg;
                desc_next.dy = dy_reg;
                desc_next.info.neg1  = neg[1];
                desc_next.info.zero1 = zero[1];
                desc_next.info.neg2  = neg[2];
                desc_next.info.zero2 = zero[2];
            end
        endcase
    end
endmodule
`default_nettype wire

[sv/tfd_queue.sv]
// Short queue of classified items between front end and back end.
`default_nettype none
module tfd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  tfd_pkg::desc_t push_desc,
    input  logic           push_valid,
    output logic           full,
    output tfd_pkg::desc_t head,
    output logic           head_valid,
    input  logic           pop
);
    import tfd_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    desc_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wp_reg, rp_reg;
    logic [CW-1:0]  cnt_reg;
    logic           push;

    assign full       = (cnt_reg == CW'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = entry_reg[rp_reg];
    assign push       = push_valid && !full;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wp_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CW'(push) - CW'(pop);
        end
    end
endmodule
`default_nettype wire

[sv/tfd_ray.sv]
// Ray pipeline: CORDIC direction and digit-by-digit radius, one ray per cycle while en is high.
`default_nettype none
module tfd_ray (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [tfd_pkg::DELTA_WIDTH-1:0]    dx,
    input  logic [tfd_pkg::DELTA_WIDTH-1:0]    dy,
    input  tfd_pkg::tag_t                      in_tag,
    output logic                               out_valid,
    output tfd_pkg::tag_t                      out_tag,
    output tfd_pkg::ray_res_t                  res
);
    import tfd_pkg::*;

    logic signed [DELTA_WIDTH-1:0] sdx, sdy;
    logic signed [PROD_WIDTH-1:0]  sqx, sqy;
    logic signed [CX_WIDTH-1:0]    ex, ey;

    logic                          p1_v_reg, p1_atp_reg;
    logic [PROD_WIDTH-1:0]         sqx_reg, sqy_reg;
    logic signed [CX_WIDTH-1:0]    p1_x_reg, p1_y_reg;
    logic [TURN_WIDTH-1:0]         p1_z_reg;
    tag_t                          p1_tag_reg;

    logic                          p2_v_reg, p2_atp_reg;
    logic [SUM_WIDTH-1:0]          p2_sum_reg;
    logic signed [CX_WIDTH-1:0]    p2_x_reg, p2_y_reg;
    logic [TURN_WIDTH-1:0]         p2_z_reg;
    tag_t                          p2_tag_reg;

    logic                          st_v   [PIPE_STAGES+1];
    logic signed [CX_WIDTH-1:0]    st_x   [PIPE_STAGES+1];
    logic signed [CX_WIDTH-1:0]    st_y   [PIPE_STAGES+1];
    logic [TURN_WIDTH-1:0]         st_z   [PIPE_STAGES+1];
    logic [SUM_WIDTH-1:0]          st_sum [PIPE_STAGES+1];
    logic [REM_WIDTH-1:0]          st_rem [PIPE_STAGES+1];
    logic [ROOT_WIDTH-1:0]         st_root[PIPE_STAGES+1];
    logic                          st_atp [PIPE_STAGES+1];
    tag_t                          st_tag [PIPE_STAGES+1];

    logic [ROOT_WIDTH:0]           rounded;

    // Squares for the radius; fold the left half plane onto the right.
    always_comb
    begin
        sdx = $signed(dx);
        sdy = $signed(dy);
        sqx = sdx * sdx;
        sqy = sdy * sdy;
        ex  = CX_WIDTH'(sdx);
        ey  = CX_WIDTH'(sdy);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg    <= sqx;
            sqy_reg    <= sqy;
            p1_x_reg   <= sdx[DELTA_WIDTH-1] ? -ex : ex;
            p1_y_reg   <= sdx[DELTA_WIDTH-1] ? -ey : ey;
            p1_z_reg   <= sdx[DELTA_WIDTH-1] ? TURN_HALF : '0;
            p1_atp_reg <= (dx == '0) && (dy == '0);
            p1_tag_reg <= in_tag;
            p2_sum_reg <= sqx_reg + sqy_reg;
            p2_x_reg   <= p1_x_reg;
            p2_y_reg   <= p1_y_reg;
            p2_z_reg   <= p1_z_reg;
            p2_atp_reg <= p1_atp_reg;
            p2_tag_reg <= p1_tag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_v_reg <= in_valid;
            p2_v_reg <= p1_v_reg;
        end
    end

    assign st_v[0]    = p2_v_reg;
    assign st_x[0]    = p2_x_reg;
    assign st_y[0]    = p2_y_reg;
    assign st_z[0]    = p2_z_reg;
    assign st_sum[0]  = p2_sum_reg;
    assign st_rem[0]  = '0;
    assign st_root[0] = '0;
    assign st_atp[0]  = p2_atp_reg;
    assign st_tag[0]  = p2_tag_reg;

    for (genvar s = 0; s < PIPE_STAGES; s++)
    begin : g_stage
        logic                       v_reg, atp_reg;
        logic signed [CX_WIDTH-1:0] x_reg, y_reg, x_next, y_next;
        logic [TURN_WIDTH-1:0]      z_reg, z_next;
        logic [SUM_WIDTH-1:0]       sum_reg;
        logic [REM_WIDTH-1:0]       rem_reg, rem_next;
        logic [ROOT_WIDTH-1:0]      root_reg, root_next;
        tag_t                       tag_reg;

        if (s < CORDIC_STEPS)
        begin : g_cordic
            // Rotate toward the x axis and accumulate the angle.
            always_comb
            begin
                if (!st_y[s][CX_WIDTH-1] && (st_y[s] != '0))
                begin
                    x_next = st_x[s] + (st_y[s] >>> s);
                    y_next = st_y[s] - (st_x[s] >>> s);
                    z_next = st_z[s] + ATAN_TURN[s];
                end
                else
                begin
                    x_next = st_x[s] - (st_y[s] >>> s);
                    y_next = st_y[s] + (st_x[s] >>> s);
                    z_next = st_z[s] - ATAN_TURN[s];
                end
            end
        end
        else
        begin : g_cpass
            assign x_next = st_x[s];
            assign y_next = st_y[s];
            assign z_next = st_z[s];
        end

        if (s < SQRT_STEPS)
        begin : g_sqrt
            localparam int K = SQRT_STEPS - 1 - s;
            logic [REM_WIDTH-1:0] remt, trial;
            // Bring down the next digit pair and try the new root bit.
            always_comb
            begin
                remt  = {st_rem[s][REM_WIDTH-3:0], st_sum[s][2*K+1 -: 2]};
                trial = REM_WIDTH'({st_root[s], 2'b01});
                if (remt >= trial)
                begin
                    rem_next  = remt - trial;
                    root_next = {st_root[s][ROOT_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = remt;
                    root_next = {st_root[s][ROOT_WIDTH-2:0], 1'b0};
                end
            end
        end
        else
        begin : g_spass
            assign rem_next  = st_rem[s];
            assign root_next = st_root[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg    <= x_next;
                y_reg    <= y_next;
                z_reg    <= z_next;
                sum_reg  <= st_sum[s];
                rem_reg  <= rem_next;
                root_reg <= root_next;
                atp_reg  <= st_atp[s];
                tag_reg  <= st_tag[s];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= st_v[s];
            end
        end

        assign st_v[s+1]    = v_reg;
        assign st_x[s+1]    = x_reg;
        assign st_y[s+1]    = y_reg;
        assign st_z[s+1]    = z_reg;
        assign st_sum[s+1]  = sum_reg;
        assign st_rem[s+1]  = rem_reg;
        assign st_root[s+1] = root_reg;
        assign st_atp[s+1]  = atp_reg;
        assign st_tag[s+1]  = tag_reg;
    end

    // Round the root half up; a zero vector points at angle zero.
    assign rounded   = {1'b0, st_root[PIPE_STAGES]}
                     + (ROOT_WIDTH+1)'(st_rem[PIPE_STAGES] > REM_WIDTH'(st_root[PIPE_STAGES]));
    assign out_valid = st_v[PIPE_STAGES];
    assign out_tag   = st_tag[PIPE_STAGES];
    assign res.turn  = st_atp[PIPE_STAGES] ? '0 : st_z[PIPE_STAGES];
    assign res.rad   = rounded[RADIUS_WIDTH-1:0];
    assign res.atp   = st_atp[PIPE_STAGES];
endmodule
`default_nettype wire

[sv/tfd_back.sv]
// Back end: ray issue, ray collection and sub-triangle emission.
`default_nettype none
`include "assert_macros.svh"
module tfd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  tfd_pkg::desc_t   q_desc,
    input  logic             q_valid,
    output logic             pop,
    output tfd_pkg::result_t result,
    output logic             result_valid,
    input  logic             result_stall
);
    import tfd_pkg::*;

    logic [1:0]             slot_reg;
    logic                   p0_v_reg;
    logic [DELTA_WIDTH-1:0] p0_dx_reg, p0_dy_reg;
    tag_t                   p0_tag_reg;

    logic     rv;
    tag_t     rtag;
    ray_res_t rres;

    ray_res_t c0_reg, c1_reg;
    ray_res_t e_ray0_reg, e_ray1_reg, e_ray2_reg;
    info_t    e_info_reg;
    logic     e_busy_reg;
    logic [1:0] e_idx_reg, nidx;

    result_t  res_reg, res_next;
    logic     res_v_reg;

    logic     adv, out_free, e_step, e_last, e_free, ld, neg;
    ray_res_t fr, sr;
    logic [TURN_WIDTH-1:0] d, fold, apex_sum, start_sum;

    assign out_free = !res_v_reg || !result_stall;
    assign e_step   = e_busy_reg && out_free;
    assign e_free   = !e_busy_reg || (e_step && e_last);
    // Freeze the ray pipeline while a completed ray set has nowhere to go.
    assign adv      = !(rv && (rtag.slot == SLOT_2) && !e_free);
    assign ld       = rv && adv && (rtag.slot == SLOT_2);
    assign pop      = adv && q_valid && (slot_reg == SLOT_2);

    assign result       = res_reg;
    assign result_valid = res_v_reg;

    // Issue the three rays of the head item, one per cycle while adv is high.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0_dx_reg       <= q_desc.dx[slot_reg];
            p0_dy_reg       <= q_desc.dy[slot_reg];
            p0_tag_reg.slot <= slot_reg;
            p0_tag_reg.info <= q_desc.info;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= SLOT_0;
            p0_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            p0_v_reg <= q_valid;
            if (q_valid)
            begin
                slot_reg <= (slot_reg == SLOT_2) ? SLOT_0 : slot_reg + 1'b1;
            end
        end
    end

    tfd_ray u_ray (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (p0_v_reg),
        .dx        (p0_dx_reg),
        .dy        (p0_dy_reg),
        .in_tag    (p0_tag_reg),
        .out_valid (rv),
        .out_tag   (rtag),
        .res       (rres)
    );

    // Pick the rays of the current sub-triangle and the next one to emit.
    always_comb
    begin
        fr     = e_ray0_reg;
        sr     = e_ray1_reg;
        neg    = 1'b0;
        e_last = 1'b1;
        nidx   = SLOT_0;
        unique case (e_idx_reg)
            SLOT_1:
            begin
                neg = e_info_reg.neg1;
                fr  = neg ? e_ray2_reg : e_ray1_reg;
                sr  = neg ? e_ray1_reg : e_ray2_reg;
                if (!e_info_reg.zero2)
                begin
                    e_last = 1'b0;
                    nidx   = SLOT_2;
                end
            end
            SLOT_2:
            begin
                neg = e_info_reg.neg2;
                fr  = neg ? e_ray0_reg : e_ray2_reg;
                sr  = neg ? e_ray2_reg : e_ray0_reg;
            end
            default:
            begin
                if (!e_info_reg.degen && !e_info_reg.zero1)
                begin
                    e_last = 1'b0;
                    nidx   = SLOT_1;
                end
                else if (!e_info_reg.degen && !e_info_reg.zero2)
                begin
                    e_last = 1'b0;
                    nidx   = SLOT_2;
                end
            end
        endcase

        d         = fr.turn - sr.turn;
        fold      = (d > TURN_HALF) ? (32'd0 - d) : d;
        apex_sum  = fold + ROUND_HALF;
        start_sum = fr.turn + ROUND_HALF;

        res_next = '0;
        if (e_info_reg.degen)
        begin
            res_next.status = ST_DEGEN;
            res_next.last   = 1'b1;
        end
        else
        begin
            res_next.status        = e_info_reg.status;
            res_next.start_angle   = start_sum[TURN_WIDTH-1 -: ANGLE_WIDTH];
            res_next.apex_angle    = (fr.atp || sr.atp) ? '0
                                   : apex_sum[TURN_WIDTH-1 -: ANGLE_WIDTH];
            res_next.first_radius  = fr.rad;
            res_next.second_radius = sr.rad;
            res_next.negative      = neg;
            res_next.last          = e_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rv && adv && (rtag.slot == SLOT_0))
        begin
            c0_reg <= rres;
        end
        if (rv && adv && (rtag.slot == SLOT_1))
        begin
            c1_reg <= rres;
        end
        if (ld)
        begin
            e_ray0_reg <= c0_reg;
            e_ray1_reg <= c1_reg;
            e_ray2_reg <= rres;
            e_info_reg <= rtag.info;
        end
        if (e_step)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_busy_reg <= 1'b0;
            e_idx_reg  <= SLOT_0;
            res_v_reg  <= 1'b0;
        end
        else
        begin
            if (ld)
            begin
                e_busy_reg <= 1'b1;
                e_idx_reg  <= SLOT_0;
            end
            else if (e_step && e_last)
            begin
                e_busy_reg <= 1'b0;
            end
            else if (e_step)
            begin
                e_idx_reg <= nidx;
            end

            if (e_step)
            begin
                res_v_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_v_reg <= 1'b0;
            end
        end
    end

    `TFD_NEVER(a_pop_empty, pop && !q_valid, "queue popped while empty")
    `TFD_NEVER(a_emit_overrun, ld && e_busy_reg && !(e_step && e_last), "emitter overwritten")
    `TFD_ASSERT(a_degen_last, res_v_reg && (res_reg.status == ST_DEGEN) |-> res_reg.last, "degenerate result not last")
endmodule
`default_nettype wire

[sv/triangle_fan_decompose.sv]
// Top level of the triangle fan decomposition block.
// Each transaction on the item channel carries three vertices and a point p.
// The front end forms the vertex deltas against p, the exact edge
// orientations, the status and the rotation that puts the first positive edge
// first, and pushes the classified item into a two-entry queue. The back end
// sends the three rays of an item, one per cycle while the ray pipeline is not
// frozen, down a 32-stage CORDIC and square-root pipeline, then emits one to
// three sub-triangles (one result for a degenerate triangle) on the result
// channel, one result transaction per cycle while result_stall is low. Sustained
// intake is bounded by the ray pipeline, which takes one ray per cycle while
// not frozen, and an item holds three rays. On its way to the first result an
// item passes the two front stages, the queue, ray issue, the two square stages
// and the 32 CORDIC stages, then the emitter and the result register.
// A stall on the result channel freezes the ray pipeline once a full ray set
// is waiting; the queue then fills and the item channel stalls.
`default_nettype none
module triangle_fan_decompose (
    input  logic             clk,
    input  logic             rst_n,
    input  tfd_pkg::item_t   item,
    input  logic             item_valid,
    output logic             item_stall,
    output tfd_pkg::result_t result,
    output logic             result_valid,
    input  logic             result_stall
);
    import tfd_pkg::*;

    desc_t f_desc, q_head;
    logic  f_valid, q_full, q_valid, q_pop;

    // Classify: orientation products, signs, rotation.
    tfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .desc       (f_desc),
        .desc_valid (f_valid),
        .desc_full  (q_full)
    );

    // Decouple the two halves so each stalls on its own.
    tfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_desc  (f_desc),
        .push_valid (f_valid),
        .full       (q_full),
        .head       (q_head),
        .head_valid (q_valid),
        .pop        (q_pop)
    );

    // Angles, radii and result emission.
    tfd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_desc       (q_head),
        .q_valid      (q_valid),
        .pop          (q_pop),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );
endmodule
`default_nettype wire

[tb/tb_triangle_fan_decompose.sv]
// Testbench for the triangle fan decomposition block: directed and random checks.
`timescale 1ns / 100ps
`default_nettype none
module tb_triangle_fan_decompose;
    import tfd_pkg::*;

    localparam logic [31:0] ATAN_STEP [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };
    localparam int CYCLE_LIMIT = 400000;

    logic    clk;
    logic    rst_n;
    item_t   item;
    logic    item_valid;
    logic    item_stall;
    result_t result;
    logic    result_valid;
    logic    result_stall;

    // Sub-triangles still owed by the block, oldest first.
    result_t fan_pending[$];
    int      mismatches;
    int      cycles;
    bit      stall_bias;

    triangle_fan_decompose u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Exact orientation sign of (a-p)x(b-p); 64-bit signed is wide enough
    // for 17-bit deltas.
    function automatic int edge_sign(longint ax, longint ay, longint bx, longint by,
                                     longint px, longint py);
        longint cross_val;
        cross_val = (ax - px) * (by - py) - (ay - py) * (bx - px);
        return (cross_val > 0) ? 1 : ((cross_val < 0) ? -1 : 0);
    endfunction

    // CORDIC vectoring in 32-bit turn units, arithmetic shifts.
    function automatic logic [31:0] ray_turn(longint x, longint y);
        logic [31:0] z;
        longint      xs;
        longint      ys;
        z = 32'd0;
        if (x == 0 && y == 0)
            return 32'd0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < 32; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_STEP[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_STEP[i];
            end
        end
        return z;
    endfunction

    // Integer square root of dx^2+dy^2, rounded half up.
    function automatic logic [RADIUS_WIDTH-1:0] ray_length(longint dx, longint dy);
        longint unsigned sum;
        longint unsigned root;
        sum  = dx * dx + dy * dy;
        root = 0;
        for (int b = 17; b >= 0; b--)
        begin
            if ((root + (64'd1 << b)) * (root + (64'd1 << b)) <= sum)
                root = root + (64'd1 << b);
        end
        // Round up when sum - root^2 exceeds root.
        if (sum - root * root > root)
            root = root + 1;
        return root[RADIUS_WIDTH-1:0];
    endfunction

    function automatic logic [ANGLE_WIDTH-1:0] round_angle(logic [32:0] t);
        logic [32:0] r;
        r = (t + (33'd1 << (31 - ANGLE_WIDTH))) >> (32 - ANGLE_WIDTH);
        return r[ANGLE_WIDTH-1:0];
    endfunction

    function automatic result_t sub_triangle(logic [1:0] st, logic [31:0] turn_a,
                                             logic [31:0] turn_b,
                                             logic [RADIUS_WIDTH-1:0] len_a,
                                             logic [RADIUS_WIDTH-1:0] len_b,
                                             bit at_a, bit at_b, bit neg);
        result_t     r;
        logic [31:0] diff;
        logic [32:0] fold;
        diff = turn_a - turn_b;
        fold = (diff > 32'h8000_0000) ? {1'b0, -diff} : {1'b0, diff};
        r.status        = st;
        r.start_angle   = round_angle({1'b0, turn_a});
        r.apex_angle    = (at_a || at_b) ? '0 : round_angle(fold);
        r.first_radius  = len_a;
        r.second_radius = len_b;
        r.negative      = neg;
        r.last          = 1'b0;
        return r;
    endfunction

    // Queue the sub-triangles one item fans into.
    task automatic predict_fan(item_t it);
        longint      vx[3];
        longint      vy[3];
        longint      px;
        longint      py;
        int          dir[3];
        int          rot_dir[3];
        int          first_pos;
        int          src;
        logic [1:0]  st;
        logic [31:0] turn[3];
        logic [RADIUS_WIDTH-1:0] len[3];
        bit          atp[3];
        result_t     r;
        result_t     fan[$];
        vx[0] = it.first_x;  vy[0] = it.first_y;
        vx[1] = it.second_x; vy[1] = it.second_y;
        vx[2] = it.third_x;  vy[2] = it.third_y;
        px = it.point_x;
        py = it.point_y;
        for (int j = 0; j < 3; j++)
            dir[j] = edge_sign(vx[j], vy[j], vx[(j+1)%3], vy[(j+1)%3], px, py);
        if (dir[0] == 0 || dir[1] == 0 || dir[2] == 0)
            st = ST_EDGE;
        else if (dir[0] < 0 || dir[1] < 0 || dir[2] < 0)
            st = ST_OUTSIDE;
        else
            st = ST_INSIDE;
        first_pos = (dir[0] > 0) ? 0 : ((dir[1] > 0) ? 1 : ((dir[2] > 0) ? 2 : -1));
        if (first_pos < 0)
        begin
            r = '0;
            r.status = ST_DEGEN;
            r.last = 1'b1;
            fan_pending.push_back(r);
            return;
        end
        for (int j = 0; j < 3; j++)
        begin
            src = (first_pos + j) % 3;
            rot_dir[j] = dir[src];
            turn[j] = ray_turn(vx[src] - px, vy[src] - py);
            len[j]  = ray_length(vx[src] - px, vy[src] - py);
            atp[j]  = (vx[src] == px && vy[src] == py);
        end
        fan.push_back(sub_triangle(st, turn[0], turn[1], len[0], len[1],
                                   atp[0], atp[1], 1'b0));
        for (int j = 1; j < 3; j++)
        begin
            int b;
            b = (j + 1) % 3;
            if (rot_dir[j] > 0)
                fan.push_back(sub_triangle(st, turn[j], turn[b], len[j], len[b],
                                           atp[j], atp[b], 1'b0));
            else if (rot_dir[j] < 0)
                fan.push_back(sub_triangle(st, turn[b], turn[j], len[b], len[j],
                                           atp[b], atp[j], 1'b1));
        end
        fan[fan.size()-1].last = 1'b1;
        foreach (fan[i])
            fan_pending.push_back(fan[i]);
    endtask

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------

    // Mostly no gap, sometimes a short one, occasionally a long one.
    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(8, 40);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // Present one transaction, hold it until accepted, then predict.
    task automatic send_item(item_t it);
        int gap;
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        predict_fan(it);
        @(negedge clk);
        gap = gap_length();
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    function automatic item_t make_item(int a, int b, int c, int d, int e, int f,
                                        int g, int h);
        item_t it;
        it = '{first_x: COORD_WIDTH'(a), first_y: COORD_WIDTH'(b),
               second_x: COORD_WIDTH'(c), second_y: COORD_WIDTH'(d),
               third_x: COORD_WIDTH'(e), third_y: COORD_WIDTH'(f),
               point_x: COORD_WIDTH'(g), point_y: COORD_WIDTH'(h)};
        return it;
    endfunction

    function automatic logic [15:0] random_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000 + $urandom_range(0, 3);
            1: return 16'h7fff - $urandom_range(0, 3);
            2: return $urandom_range(0, 16) - 8;
            default: return $urandom;
        endcase
    endfunction

    // Random result-side backpressure, in bursts.
    always @(negedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else if ($urandom_range(0, 99) < 3)
            result_stall <= 1'b1;
        else if (stall_bias)
            result_stall <= ($urandom_range(0, 3) == 0);
        else
            result_stall <= result_stall && ($urandom_range(0, 4) != 0);
    end

    // Compare every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (fan_pending.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result %p", $time, result);
            end
            else
            begin
                want = fan_pending.pop_front();
                if (result !== want)
                begin
                    mismatches++;
                    $display("%0t: mismatch expected %p actual %p", $time, want, result);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic wait_drained();
        while (fan_pending.size() != 0)
            @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Inside, outside, on-edge, degenerate, vertex at p, extremes, pi direction.
    task automatic test_directed();
        send_item(make_item(0, 0, 100, 0, 0, 100, 10, 10));
        send_item(make_item(0, 0, 0, 100, 100, 0, 10, 10));
        send_item(make_item(0, 0, 100, 0, 0, 100, 200, 200));
        send_item(make_item(0, 0, 100, 0, 0, 100, 50, 0));
        send_item(make_item(0, 0, 100, 0, 0, 100, 0, 0));
        send_item(make_item(0, 0, 10, 10, 20, 20, 5, 7));
        send_item(make_item(5, 5, 5, 5, 5, 5, 5, 5));
        send_item(make_item(-32768, -32768, 32767, -32768, 0, 32767, 0, 0));
        send_item(make_item(-32768, -32768, 32767, -32768, 32767, 32767,
                            32767, 32767));
        send_item(make_item(-32768, 0, 0, -32768, 32767, 32767, -32768, 32767));
        send_item(make_item(-32768, -32768, 32767, 32767, -32768, 32767,
                            32767, -32768));
        send_item(make_item(-10, 0, 0, -10, 10, 10, 0, 0));
        send_item(make_item(-100, 0, 100, 0, 0, 100, 0, -1));
        send_item(make_item(-100, 0, 100, -5, 100, 5, 0, 0));
        send_item(make_item(1, 0, 0, 1, -1, 0, 0, -1));
        send_item(make_item(32767, 32767, -32768, -32768, 0, 1, -1, 0));
        send_item(make_item(-1, -1, -1, -1, -1, -1, -1, -1));
        send_item(make_item(3, -7, -7, 3, 9, 9, 3, -7));
    endtask

    // Random triangles, mixed small and full-range coordinates.
    task automatic test_random(int count);
        item_t it;
        for (int n = 0; n < count; n++)
        begin
            it = make_item(random_coord(), random_coord(), random_coord(),
                           random_coord(), random_coord(), random_coord(),
                           random_coord(), random_coord());
            // Put p on a vertex now and then.
            if ($urandom_range(0, 15) == 0)
            begin
                it.point_x = it.second_x;
                it.point_y = it.second_y;
            end
            send_item(it);
        end
    endtask

    // Hold off intake until the block has drained, then stream under heavy stall.
    task automatic test_drain_and_pressure();
        item_valid <= 1'b0;
        wait_drained();
        stall_bias = 1'b1;
        test_random(60);
        stall_bias = 1'b0;
    endtask

    // Back-to-back intake with no gaps between items.
    task automatic test_streaming();
        item_t it;
        for (int n = 0; n < 40; n++)
        begin
            it = make_item($urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom);
            item       <= it;
            item_valid <= 1'b1;
            do
                @(posedge clk);
            while (item_stall);
            predict_fan(it);
            @(negedge clk);
        end
    endtask

    initial
    begin
        mismatches   = 0;
        cycles       = 0;
        stall_bias   = 1'b0;
        rst_n        = 1'b0;
        item         = '0;
        item_valid   = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(200);
        test_drain_and_pressure();
        test_streaming();
        test_random(150);
        item_valid <= 1'b0;
        wait_drained();
        repeat (60) @(negedge clk);
        if (mismatches == 0 && fan_pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
+incdir+sv
sv/tfd_pkg.sv
sv/tfd_front.sv
sv/tfd_queue.sv
sv/tfd_ray.sv
sv/tfd_back.sv
sv/triangle_fan_decompose.sv
tb/tb_triangle_fan_decompose.sv
